@@ sv/contiguous_block_allocator_top_defines.svh @@
// Assertion macros used by the allocator top level.
`ifndef CONTIGUOUS_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define CONTIGUOUS_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CBA_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CBA_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/cba_pkg.sv @@
// Types and constants shared by the contiguous block allocator.
`default_nettype none
package cba_pkg;

    // Default heap size in blocks.
    localparam int HEAP_BLOCKS_DEF = 32;

    // Fixed field widths.
    localparam int SIZE_W   = 6;
    localparam int START_W  = 5;
    localparam int STATUS_W = 2;
    localparam int POLICY_W = 2;

    // Request function codes.
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Fit policy codes.
    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_NEXT  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd2;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

    // Request beat.
    typedef struct packed {
        logic               func;
        logic [SIZE_W-1:0]  request_size;
        logic [START_W-1:0] free_start;
    } cba_req_t;

    // Result beat.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [START_W-1:0]  alloc_start;
    } cba_rsp_t;

    // Sequencer controls for the run unit.
    typedef struct packed {
        logic clear;
        logic step;
        logic blk_free;
        logic last;
    } cba_run_ctl_t;

    // Run unit status toward the sequencer.
    typedef struct packed {
        logic hit_now;
        logic run_open;
        logic final_found;
    } cba_run_sts_t;

endpackage
`default_nettype wire

@@ sv/cba_run_unit.sv @@
// Free-run tracker and fit compare unit, fed one map block per cycle while step is set.
`default_nettype none
module cba_run_unit #(
    parameter int HEAP_BLOCKS = cba_pkg::HEAP_BLOCKS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire cba_pkg::cba_run_ctl_t         ctl,
    input  wire logic [$clog2(HEAP_BLOCKS)-1:0] pos,
    input  wire logic [cba_pkg::POLICY_W-1:0]  policy,
    input  wire logic [cba_pkg::SIZE_W-1:0]    req_size,
    output cba_pkg::cba_run_sts_t              sts,
    output logic [$clog2(HEAP_BLOCKS)-1:0]     run_start
);
    import cba_pkg::*;

    localparam int IDX_W = $clog2(HEAP_BLOCKS);
    localparam int LEN_W = $clog2(HEAP_BLOCKS + 1);
    localparam int CMP_W = ((LEN_W > SIZE_W) ? LEN_W : SIZE_W) + 1;

    logic [LEN_W-1:0] run_len_reg,    run_len_next;
    logic [IDX_W-1:0] run_start_reg,  run_start_next;
    logic             found_reg,      found_next;
    logic [IDX_W-1:0] best_start_reg, best_start_next;
    logic [LEN_W-1:0] best_len_reg,   best_len_next;

    logic [LEN_W-1:0] new_len;
    logic [IDX_W-1:0] cur_start;
    logic [LEN_W-1:0] cand_len;
    logic             close_run;
    logic             fits;
    logic             better;
    logic             cand_ok;
    logic             first_like;

    // Length and start of the run that includes the current block, and the fit checks.
    always_comb begin
        new_len    = ctl.blk_free ? (run_len_reg + LEN_W'(1)) : run_len_reg;
        cur_start  = (run_len_reg == '0) ? pos : run_start_reg;
        cand_len   = new_len;
        close_run  = ((run_len_reg != '0) && !ctl.blk_free) || (ctl.blk_free && ctl.last);
        fits       = CMP_W'(cand_len) >= CMP_W'(req_size);
        first_like = (policy == POL_FIRST) || (policy == POL_NEXT);
        better     = !found_reg
                   || ((policy == POL_BEST)  && (cand_len < best_len_reg))
                   || ((policy == POL_WORST) && (cand_len > best_len_reg));
        cand_ok    = !first_like && close_run && fits && better;
    end

    // Status toward the sequencer.
    always_comb begin
        sts.hit_now     = first_like && ctl.blk_free && fits;
        sts.run_open    = run_len_reg != '0;
        sts.final_found = cand_ok || found_reg;
        run_start       = (sts.hit_now || cand_ok) ? cur_start : best_start_reg;
    end

    // Run and candidate updates.
    always_comb begin
        run_len_next    = run_len_reg;
        run_start_next  = run_start_reg;
        found_next      = found_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        if (ctl.clear) begin
            run_len_next = '0;
            found_next   = 1'b0;
        end else if (ctl.step) begin
            run_len_next   = ctl.blk_free ? new_len : '0;
            run_start_next = cur_start;
            if (cand_ok) begin
                found_next      = 1'b1;
                best_start_next = cur_start;
                best_len_next   = cand_len;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_len_reg <= '0;
            found_reg   <= 1'b0;
        end else begin
            run_len_reg <= run_len_next;
            found_reg   <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        run_start_reg  <= run_start_next;
        best_start_reg <= best_start_next;
        best_len_reg   <= best_len_next;
    end

endmodule
`default_nettype wire

@@ sv/contiguous_block_allocator_top.sv @@
// Top level of the contiguous block allocator: map, sequencer and beat ports.
// The allocator keeps one occupancy bit per heap block in flip-flops (all free after
// reset, no clearing pass) and answers each request with one result beat. A free, a
// zero-size allocate or an allocate larger than the heap goes from accept straight to
// the result state. An allocate runs the run unit over the map at one block per cycle:
// first, best and worst fit scan from block 0 (first fit stops at the first fitting
// run); next fit scans from its pointer to the heap end and then from block 0. The
// result state loads the output register once it is free or taken, and a new request
// is taken only after the sequencer is back in idle, so the block does not accept a
// new request before it is through with the last one. The fit policy is written
// through cfg_we.
`default_nettype none
`include "contiguous_block_allocator_top_defines.svh"
module contiguous_block_allocator_top #(
    parameter int HEAP_BLOCKS = cba_pkg::HEAP_BLOCKS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic [cba_pkg::POLICY_W-1:0] cfg_wdata,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire cba_pkg::cba_req_t            s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output cba_pkg::cba_rsp_t                 m_data
);
    import cba_pkg::*;

    localparam int IDX_W = $clog2(HEAP_BLOCKS);
    localparam int LEN_W = $clog2(HEAP_BLOCKS + 1);
    localparam int CMP_W = ((LEN_W > SIZE_W) ? LEN_W : SIZE_W) + 1;
    localparam logic [CMP_W-1:0] H_X = CMP_W'(HEAP_BLOCKS);
    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(HEAP_BLOCKS - 1);

    // Sequencer states.
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_RESULT = 2'd2;

    logic [1:0]             state_reg,  state_next;
    logic [HEAP_BLOCKS-1:0] occ_reg,    occ_next;
    logic [IDX_W-1:0]       nss_reg,    nss_next;
    logic [POLICY_W-1:0]    policy_reg;
    cba_req_t               req_reg,    req_next;
    logic [IDX_W-1:0]       pos_reg,    pos_next;
    logic [IDX_W-1:0]       ptr_reg,    ptr_next;
    logic                   pass_b_reg, pass_b_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [IDX_W-1:0]       where_reg,  where_next;
    logic                   m_valid_reg, m_valid_next;
    cba_rsp_t               m_data_reg,  m_data_next;

    cba_run_ctl_t           run_ctl;
    cba_run_sts_t           run_sts;
    logic [IDX_W-1:0]       run_start;

    logic [CMP_W-1:0]       mask_start;
    logic [CMP_W-1:0]       mask_end;
    logic [HEAP_BLOCKS-1:0] run_mask;
    logic [CMP_W-1:0]       in_size_x;
    logic [CMP_W-1:0]       in_start_x;
    logic                   free_bad;
    logic [CMP_W-1:0]       alloc_end;
    logic                   alloc_commit;
    logic                   bw_policy;

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Shared run unit, one map block per scan cycle.
    cba_run_unit #(
        .HEAP_BLOCKS (HEAP_BLOCKS)
    ) u_run (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (run_ctl),
        .pos       (pos_reg),
        .policy    (policy_reg),
        .req_size  (req_reg.request_size),
        .sts       (run_sts),
        .run_start (run_start)
    );

    // Run mask for a free at accept or an allocate at commit.
    always_comb begin
        in_size_x  = CMP_W'(s_data.request_size);
        in_start_x = CMP_W'(s_data.free_start);
        free_bad   = (in_size_x == '0) || (in_start_x >= H_X) || ((in_start_x + in_size_x) > H_X);
        if (state_reg == S_IDLE) begin
            mask_start = in_start_x;
            mask_end   = in_start_x + in_size_x;
        end else begin
            mask_start = CMP_W'(run_start);
            mask_end   = CMP_W'(run_start) + CMP_W'(req_reg.request_size);
        end
        for (int i = 0; i < HEAP_BLOCKS; i++) begin
            run_mask[i] = (CMP_W'(i) >= mask_start) && (CMP_W'(i) < mask_end);
        end
        alloc_end = CMP_W'(run_start) + CMP_W'(req_reg.request_size);
        bw_policy = (policy_reg == POL_BEST) || (policy_reg == POL_WORST);
    end

    // Sequencer.
    always_comb begin
        state_next   = state_reg;
        occ_next     = occ_reg;
        nss_next     = nss_reg;
        req_next     = req_reg;
        pos_next     = pos_reg;
        ptr_next     = ptr_reg;
        pass_b_next  = pass_b_reg;
        status_next  = status_reg;
        where_next   = where_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        alloc_commit = 1'b0;
        run_ctl.clear    = 1'b0;
        run_ctl.step     = 1'b0;
        run_ctl.blk_free = !occ_reg[pos_reg];
        run_ctl.last     = pos_reg == LAST_POS;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next   = s_data;
                    where_next = '0;
                    state_next = S_RESULT;
                    if (s_data.func == FUNC_ALLOC) begin
                        if (in_size_x == '0) begin
                            status_next = ST_BAD;
                        end else if (in_size_x > H_X) begin
                            status_next = ST_OOM;
                        end else begin
                            state_next    = S_SCAN;
                            pos_next      = (policy_reg == POL_NEXT) ? nss_reg : '0;
                            ptr_next      = nss_reg;
                            pass_b_next   = 1'b0;
                            run_ctl.clear = 1'b1;
                        end
                    end else begin
                        if (free_bad) begin
                            status_next = ST_BAD;
                        end else begin
                            status_next = ST_DONE;
                            occ_next    = occ_reg & ~run_mask;
                        end
                    end
                end
            end
            S_SCAN: begin
                run_ctl.step = 1'b1;
                if (pass_b_reg && !run_sts.run_open && (pos_reg >= ptr_reg)) begin
                    // Wrapped search reached the pointer with no open run.
                    status_next = ST_OOM;
                    state_next  = S_RESULT;
                end else if (run_sts.hit_now || (run_ctl.last && bw_policy
                                                 && run_sts.final_found)) begin
                    alloc_commit = 1'b1;
                end else if (run_ctl.last) begin
                    if ((policy_reg == POL_NEXT) && !pass_b_reg && (ptr_reg != '0)) begin
                        pass_b_next   = 1'b1;
                        pos_next      = '0;
                        run_ctl.clear = 1'b1;
                    end else begin
                        status_next = ST_OOM;
                        state_next  = S_RESULT;
                    end
                end else begin
                    pos_next = pos_reg + IDX_W'(1);
                end
                if (alloc_commit) begin
                    status_next = ST_DONE;
                    where_next  = run_start;
                    occ_next    = occ_reg | run_mask;
                    nss_next    = (alloc_end >= H_X) ? '0 : IDX_W'(alloc_end);
                    state_next  = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.status      = status_reg;
                    m_data_next.alloc_start = START_W'(where_reg);
                    state_next              = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            occ_reg     <= '0;
            nss_reg     <= '0;
            policy_reg  <= POL_FIRST;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            nss_reg     <= nss_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                policy_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        pos_reg    <= pos_next;
        ptr_reg    <= ptr_next;
        pass_b_reg <= pass_b_next;
        status_reg <= status_next;
        where_reg  <= where_next;
        m_data_reg <= m_data_next;
    end

    // A committed allocation marks its first block used.
    `CBA_ASSERT_NEXT(a_alloc_marks_map, aclk, aresetn, alloc_commit, occ_reg[$past(where_next)], "allocated block not marked used")
    // Failed or rejected results carry a zero start.
    `CBA_ASSERT_IMP(a_fail_zero_start, aclk, aresetn, m_valid_reg && (m_data_reg.status != ST_DONE), m_data_reg.alloc_start == '0, "nonzero start on failed result")
    // Only defined status codes leave the block.
    `CBA_ASSERT_IMP(a_status_code, aclk, aresetn, m_valid_reg, (m_data_reg.status == ST_DONE) || (m_data_reg.status == ST_OOM) || (m_data_reg.status == ST_BAD), "undefined status code")
    // The next fit pointer stays inside the heap.
    `CBA_ASSERT_IMP(a_nss_range, aclk, aresetn, 1'b1, nss_reg <= LAST_POS, "next fit pointer past heap end")
    // The scan position stays inside the heap.
    `CBA_ASSERT_IMP(a_pos_range, aclk, aresetn, state_reg == S_SCAN, pos_reg <= LAST_POS, "scan position past heap end")

endmodule
`default_nettype wire

@@ sim/tb_contiguous_block_allocator_top.sv @@
// Self-checking testbench for the contiguous block allocator: directed table, then random traffic.
`timescale 1ns / 1ps
module tb_contiguous_block_allocator_top;
    import cba_pkg::*;

    localparam int HB = HEAP_BLOCKS_DEF;
    localparam int N_ROWS = 28;
    localparam int N_PHASES = 8;
    localparam int PHASE_ITEMS = 180;
    localparam int LONG_STALL = 300;

    // Policy order of the random phases; both extremes appear more than once.
    localparam logic [POLICY_W-1:0] POL_PLAN [N_PHASES] = '{
        POL_NEXT, POL_WORST, POL_BEST, POL_FIRST, POL_NEXT, POL_BEST, POL_WORST, POL_FIRST
    };

    typedef enum logic {ROW_SEND, ROW_SET_POLICY} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [POLICY_W-1:0]   pol;
        cba_req_t              req;
        bit                    known;
        cba_rsp_t              want;
    } dir_row_t;

    typedef struct {
        int unsigned start;
        int unsigned len;
    } span_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_we = 1'b0;
    logic [POLICY_W-1:0] cfg_wdata = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    cba_req_t            s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    cba_rsp_t            m_data;

    // Shadow state of the allocator.
    logic [HB-1:0]       occ_map = '0;
    logic [START_W-1:0]  search_ptr = '0;
    logic [POLICY_W-1:0] fit_pol = POL_FIRST;

    cba_rsp_t    due_results [$];
    span_t       live_runs [$];
    dir_row_t    dir_rows [N_ROWS];
    int unsigned sent_count = 0;
    int unsigned mismatches = 0;
    int unsigned n_placed = 0, n_oom = 0, n_bad = 0, n_freed = 0;
    int unsigned n_settings = 0, hold_offs = 0;

    contiguous_block_allocator_top #(
        .HEAP_BLOCKS(HB)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Length of the free run that starts at block p, cut at the heap end.
    function automatic int unsigned free_run_len(input int unsigned p);
        int unsigned n;
        n = 0;
        while (p + n < HB && !occ_map[p + n]) n++;
        return n;
    endfunction

    // Searches for a run of at least size blocks under the current policy.
    function automatic bit find_fit(input int unsigned size, output int unsigned where);
        int unsigned p, len, best_p, best_len, ptr;
        bit found;
        found = 1'b0;
        best_p = 0;
        best_len = 0;
        where = 0;
        if (fit_pol == POL_NEXT) begin
            // From the pointer to the heap end, a free block at the pointer opens a run.
            ptr = search_ptr;
            for (p = ptr; p < HB; p++) begin
                if (!occ_map[p] && (p == ptr || occ_map[p - 1]) && free_run_len(p) >= size) begin
                    where = p;
                    return 1'b1;
                end
            end
            // Then wrap around and look at whole runs below the pointer.
            for (p = 0; p < ptr; p++) begin
                if (!occ_map[p] && (p == 0 || occ_map[p - 1]) && free_run_len(p) >= size) begin
                    where = p;
                    return 1'b1;
                end
            end
            return 1'b0;
        end
        p = 0;
        while (p < HB) begin
            if (occ_map[p]) begin
                p++;
                continue;
            end
            len = free_run_len(p);
            if (len >= size) begin
                if (fit_pol == POL_FIRST) begin
                    where = p;
                    return 1'b1;
                end
                // Strict comparisons keep the earliest run on ties.
                if (!found || (fit_pol == POL_BEST && len < best_len) ||
                    (fit_pol == POL_WORST && len > best_len)) begin
                    found = 1'b1;
                    best_p = p;
                    best_len = len;
                end
            end
            p += len;
        end
        where = best_p;
        return found;
    endfunction

    // Applies one request to the shadow heap and returns the result beat it should give.
    function automatic cba_rsp_t serve_request(input cba_req_t r);
        cba_rsp_t    rsp;
        int unsigned size, fs, where;
        size = r.request_size;
        fs = r.free_start;
        where = 0;
        rsp = '0;
        rsp.status = ST_DONE;
        if (r.func == FUNC_ALLOC) begin
            if (size == 0) begin
                rsp.status = ST_BAD;
            end else if (size > HB || !find_fit(size, where)) begin
                rsp.status = ST_OOM;
            end else begin
                for (int i = 0; i < size; i++) occ_map[where + i] = 1'b1;
                search_ptr = (where + size >= HB) ? '0 : START_W'(where + size);
                rsp.alloc_start = START_W'(where);
                live_runs.push_back('{where, size});
            end
        end else begin
            if (size == 0 || fs >= HB || size > HB - fs) begin
                rsp.status = ST_BAD;
            end else begin
                for (int i = 0; i < size; i++) occ_map[fs + i] = 1'b0;
            end
        end
        if (rsp.status == ST_BAD) n_bad++;
        else if (rsp.status == ST_OOM) n_oom++;
        else if (r.func == FUNC_ALLOC) n_placed++;
        else n_freed++;
        return rsp;
    endfunction

    // Idle cycles before a beat; the first 15 beats of every 60 run without gaps.
    function automatic int unsigned idle_cycles(input int unsigned k);
        return (k % 60 < 15) ? 0 : $urandom_range(0, 17);
    endfunction

    // Mostly well-formed allocate and free traffic, with some noise and bad requests.
    function automatic cba_req_t pick_request();
        cba_req_t    r;
        int unsigned roll, k;
        span_t       s;
        roll = $urandom_range(0, 99);
        r.func = FUNC_ALLOC;
        r.free_start = START_W'($urandom_range(0, HB - 1));
        r.request_size = SIZE_W'($urandom_range(1, 6));
        if (roll >= 50 && roll < 85 && live_runs.size() != 0) begin
            // Give back a run that was handed out earlier.
            k = $urandom_range(0, live_runs.size() - 1);
            s = live_runs[k];
            live_runs.delete(k);
            r.func = FUNC_FREE;
            r.free_start = START_W'(s.start);
            r.request_size = SIZE_W'(s.len);
        end else if (roll >= 85 && roll < 87) begin
            // Release the whole heap.
            live_runs.delete();
            r.func = FUNC_FREE;
            r.free_start = '0;
            r.request_size = SIZE_W'(HB);
        end else if (roll >= 87) begin
            r = $bits(cba_req_t)'($urandom);
        end else begin
            case ($urandom_range(0, 19))
                0: begin
                    r.request_size = SIZE_W'($urandom_range(0, 63));
                end
                1, 2, 3, 4: begin
                    r.request_size = SIZE_W'($urandom_range(1, 16));
                end
                default: begin
                end
            endcase
        end
        return r;
    endfunction

    function automatic dir_row_t req_row(input logic func, input int unsigned size,
                                         input int unsigned start, input bit known = 1'b0,
                                         input logic [STATUS_W-1:0] st = ST_DONE,
                                         input int unsigned at = 0);
        dir_row_t row;
        row.kind = ROW_SEND;
        row.pol = POL_FIRST;
        row.req.func = func;
        row.req.request_size = SIZE_W'(size);
        row.req.free_start = START_W'(start);
        row.known = known;
        row.want.status = st;
        row.want.alloc_start = START_W'(at);
        return row;
    endfunction

    function automatic dir_row_t policy_row(input logic [POLICY_W-1:0] pol);
        dir_row_t row;
        row = req_row(FUNC_ALLOC, 0, 0);
        row.kind = ROW_SET_POLICY;
        row.pol = pol;
        return row;
    endfunction

    // Offers one request beat after a random gap and records its expected result.
    task automatic send_beat(input cba_req_t r, input bit known, input cba_rsp_t want);
        int unsigned gap;
        cba_rsp_t    got;
        gap = idle_cycles(sent_count);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= r;
        do @(posedge aclk); while (!s_ready);
        got = serve_request(r);
        due_results.push_back(known ? want : got);
        sent_count++;
    endtask

    // Writes the fit policy once the block has answered everything.
    task automatic set_policy(input logic [POLICY_W-1:0] pol);
        s_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= pol;
        @(posedge aclk);
        cfg_we <= 1'b0;
        fit_pol = pol;
        n_settings++;
    endtask

    // Result side: random stalls, plus a long hold-off now and then so the block backs up.
    initial begin : result_sink
        int unsigned stall;
        int unsigned beats;
        beats = 0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (beats % 500 == 250) begin
                stall = LONG_STALL;
                hold_offs++;
            end else begin
                stall = idle_cycles(beats + 30);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            beats++;
        end
    end

    // Compares each result beat with the oldest expectation.
    always @(posedge aclk) begin : result_check
        cba_rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                $error("result beat with no request awaiting it: status %0d, alloc_start %0d",
                       m_data.status, m_data.alloc_start);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_data.status);
                    mismatches++;
                end
                if (m_data.alloc_start !== want.alloc_start) begin
                    $error("alloc_start: expected %0d, actual %0d",
                           want.alloc_start, m_data.alloc_start);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        int unsigned ph, k;
        dir_rows = '{
            // Rejected and oversized requests on an empty heap.
            req_row(FUNC_ALLOC, 0, 0, 1'b1, ST_BAD, 0),
            req_row(FUNC_ALLOC, 33, 31, 1'b1, ST_OOM, 0),
            req_row(FUNC_ALLOC, 63, 0, 1'b1, ST_OOM, 0),
            req_row(FUNC_FREE, 2, 31, 1'b1, ST_BAD, 0),
            req_row(FUNC_FREE, 0, 0, 1'b1, ST_BAD, 0),
            req_row(FUNC_FREE, 63, 0, 1'b1, ST_BAD, 0),
            // Fill the whole heap, overflow it, empty it again, then take blocks 0 to 3.
            req_row(FUNC_ALLOC, 32, 0, 1'b1, ST_DONE, 0),
            req_row(FUNC_ALLOC, 1, 0, 1'b1, ST_OOM, 0),
            req_row(FUNC_FREE, 1, 31, 1'b1, ST_DONE, 0),
            req_row(FUNC_FREE, 32, 0, 1'b1, ST_DONE, 0),
            req_row(FUNC_FREE, 3, 5, 1'b1, ST_DONE, 0),
            req_row(FUNC_ALLOC, 4, 0, 1'b1, ST_DONE, 0),
            // Carve holes of 2, 5 and 10 blocks.
            req_row(FUNC_ALLOC, 2, 0),
            req_row(FUNC_ALLOC, 8, 0),
            req_row(FUNC_ALLOC, 5, 0),
            req_row(FUNC_ALLOC, 3, 0),
            req_row(FUNC_FREE, 2, 4),
            req_row(FUNC_FREE, 5, 14),
            // Best fit takes the smallest hole, worst fit the largest.
            policy_row(POL_BEST),
            req_row(FUNC_ALLOC, 2, 0),
            policy_row(POL_WORST),
            req_row(FUNC_ALLOC, 1, 0),
            // Next fit: from the pointer, then wrapping, then a pointer on a free block.
            policy_row(POL_NEXT),
            req_row(FUNC_ALLOC, 6, 0),
            req_row(FUNC_ALLOC, 4, 0),
            req_row(FUNC_ALLOC, 1, 0),
            req_row(FUNC_ALLOC, 20, 0),
            policy_row(POL_FIRST)
        };
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_SET_POLICY) begin
                set_policy(dir_rows[i].pol);
            end else begin
                send_beat(dir_rows[i].req, dir_rows[i].known, dir_rows[i].want);
            end
        end

        // Random phases, one policy setting each.
        for (ph = 0; ph < N_PHASES; ph++) begin
            set_policy(POL_PLAN[ph]);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                send_beat(pick_request(), 1'b0, '0);
            end
        end

        // Drain, then allow for the longest next fit scan.
        s_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (2 * HB + 4) @(posedge aclk);

        $display("Covered %0d requests: %0d placed, %0d out of memory, %0d rejected, %0d freed.",
                 sent_count, n_placed, n_oom, n_bad, n_freed);
        $display("Fit policy written %0d times; result side held off %0d times for %0d cycles.",
                 n_settings, hold_offs, LONG_STALL);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #3_000_000;
        $display("Timeout with %0d results outstanding.", due_results.size());
        $display("simulation failed");
        $finish;
    end

endmodule
